// ----- design/gtwq_pkg.sv -----
// shared types and constants for the generation tagged work queue
package gtwq_pkg;

	localparam logic [2:0] ACT_ENQ      = 3'd0;
	localparam logic [2:0] ACT_DEQ      = 3'd1;
	localparam logic [2:0] ACT_SETGEN   = 3'd2;
	localparam logic [2:0] ACT_NOTESRC  = 3'd3;
	localparam logic [2:0] ACT_NOTECB   = 3'd4;
	localparam logic [2:0] ACT_CONSUME  = 3'd5;
	localparam logic [2:0] ACT_CLASSIFY = 3'd6;

	localparam logic [1:0] SRC_NONE = 2'd0;

	localparam logic [2:0] VERD_NONE      = 3'd0;
	localparam logic [2:0] VERD_NO_SOURCE = 3'd1;
	localparam logic [2:0] VERD_NOT_ENQ   = 3'd2;
	localparam logic [2:0] VERD_NOT_DELIV = 3'd3;
	localparam logic [2:0] VERD_CTX_INV   = 3'd4;
	localparam logic [2:0] VERD_NATURAL   = 3'd5;

	// status flag bits
	localparam logic [5:0] F_ENQ = 6'h01;
	localparam logic [5:0] F_DEQ = 6'h02;
	localparam logic [5:0] F_NAT = 6'h04;
	localparam logic [5:0] F_SRC = 6'h08;
	localparam logic [5:0] F_FRC = 6'h10;
	localparam logic [5:0] F_STL = 6'h20;

	// one queue entry
	typedef struct packed {
		logic [1:0]  source;
		logic        forced;
		logic [31:0] evt_num;
		logic [31:0] owner_mod;
		logic [31:0] generation;
		logic [31:0] handler;
	} entry_t;

	// per-cycle command to every cell
	typedef struct packed {
		logic        shift;    // cells take their right neighbor
		logic        load;     // cell at load index takes new entry
		logic        squeeze;  // compaction step active
		logic [31:0] dead_gen;
	} cell_ctl_t;

endpackage

// ----- design/gtwq_cell.sv -----
// one queue cell: holds an entry and hands it to its left neighbor
module gtwq_cell
	import gtwq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      load_here,
	input  entry_t    new_entry,
	input  entry_t    right_entry,
	input  logic      right_valid,
	input  logic      left_dead,   // a dead entry sits left of here
	output entry_t    entry,
	output logic      valid,
	output logic      dead_here    // left_dead or this entry dead
);

	entry_t entry_q;
	logic   valid_q;
	logic   mine_dead;

	assign mine_dead = valid_q && (entry_q.generation == ctl.dead_gen);
	assign dead_here = left_dead || mine_dead;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift || (ctl.squeeze && dead_here)) begin
			valid_q <= right_valid;
		end else if (load_here) begin
			valid_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctl.shift || (ctl.squeeze && dead_here)) begin
			entry_q <= right_entry;
		end else if (load_here) begin
			entry_q <= new_entry;
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;

endmodule

// ----- design/generation_tagged_work_queue.sv -----
// top level: control, status registers and the row of queue cells
// the result is valid in the cycle after the input transfer for every action but a generation change
// a generation change holds its result while the compaction removes the dead entries one by one
// the next input waits for the result transfer
// no new item is taken while the compaction runs or a result waits
// reset (arst_n low) empties the queue, clears flags, window, live ids; event counter to one
module generation_tagged_work_queue
	import gtwq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 32,
	parameter int POST_WINDOW = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [1:0]  source,
	input  logic [31:0] evt_num,
	input  logic [31:0] owner_mod,
	input  logic [31:0] generation,
	input  logic [31:0] handler,
	input  logic        forced,
	input  logic [7:0]  nest_level,
	input  logic        in_guest,
	input  logic        init_zero,
	input  logic        caller_saw_source,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic [1:0]  out_source,
	output logic [31:0] out_evt_num,
	output logic [31:0] out_owner_mod,
	output logic [31:0] out_generation,
	output logic [31:0] out_handler,
	output logic        out_forced,
	output logic [5:0]  queue_count,
	output logic [2:0]  verdict,
	output logic [3:0]  post_slots_left
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int PW = $clog2(POST_WINDOW + 1);

	logic [CW-1:0] fill_q;
	logic [31:0]   next_event_q, live_mod_q, live_gen_q, dead_gen_q;
	logic [5:0]    flags_q;
	logic [PW-1:0] slots_q;
	logic          squeeze_q;

	entry_t    cell_e [QUEUE_DEPTH+1];
	logic      cell_v [QUEUE_DEPTH+1];
	logic      cell_dh [QUEUE_DEPTH];
	cell_ctl_t ctl;
	entry_t    new_e;
	logic      do_enq, do_deq, fire, any_dead, gen_change;

	// output register
	logic        acc_q, ofrc_q;
	logic [1:0]  osrc_q;
	logic [31:0] oev_q, omod_q, ogen_q, ohnd_q;
	logic [2:0]  verd_q;

	assign in_ready = !squeeze_q && !out_valid;
	assign fire     = in_valid && in_ready;

	// enqueue fill-in, stale checks and command decode
	logic [31:0] ev_f, mod_f, gen_f;
	logic        enq_ok, enq_stale, head_stale;
	always_comb begin
		ev_f  = (evt_num == '0) ? next_event_q : evt_num;
		mod_f = (owner_mod == '0) ? live_mod_q : owner_mod;
		gen_f = (generation == '0) ? live_gen_q : generation;
		enq_ok = (source != SRC_NONE) && (fill_q < CW'(QUEUE_DEPTH));
		enq_stale = (live_gen_q != '0) && (gen_f != '0) && (gen_f != live_gen_q);
		head_stale = (live_gen_q != '0) && (cell_e[0].generation != '0)
			&& (cell_e[0].generation != live_gen_q);
		gen_change = (live_gen_q != '0) && (generation != '0) && (live_gen_q != generation);
		new_e = '{source: source, forced: forced, evt_num: ev_f,
			owner_mod: mod_f, generation: gen_f, handler: handler};
		do_enq = fire && (action == ACT_ENQ) && enq_ok && !enq_stale;
		do_deq = fire && (action == ACT_DEQ) && (nest_level == '0) && (fill_q != '0);
		ctl.shift    = do_deq;
		ctl.load     = do_enq;
		ctl.squeeze  = squeeze_q;
		ctl.dead_gen = dead_gen_q;
	end

	// row of cells
	assign cell_e[QUEUE_DEPTH] = '0;
	assign cell_v[QUEUE_DEPTH] = 1'b0;
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic dl;
		if (i == 0) begin : g_first
			assign dl = 1'b0;
		end else begin : g_rest
			assign dl = cell_dh[i-1];
		end
		gtwq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.load_here  (ctl.load && (fill_q[IW-1:0] == IW'(i))),
			.new_entry  (new_e),
			.right_entry(cell_e[i+1]),
			.right_valid(cell_v[i+1]),
			.left_dead  (dl),
			.entry      (cell_e[i]),
			.valid      (cell_v[i]),
			.dead_here  (cell_dh[i])
		);
	end
	assign any_dead = cell_dh[QUEUE_DEPTH-1];

	// control and status state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0; next_event_q <= 32'd1; live_mod_q <= '0; live_gen_q <= '0;
			dead_gen_q <= '0; flags_q <= '0; slots_q <= '0; squeeze_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (squeeze_q) begin
				if (any_dead) fill_q <= fill_q - CW'(1);
				else begin
					squeeze_q <= 1'b0;
					out_valid <= 1'b1;
				end
			end
			if (fire) begin
				// a generation change holds its result until compaction ends
				out_valid <= !(action == ACT_SETGEN && gen_change);
				unique case (action)
					ACT_ENQ: if (enq_ok) begin
						if (evt_num == '0) next_event_q <= next_event_q + 32'd1;
						if (enq_stale) flags_q <= flags_q | F_STL;
						else begin
							fill_q <= fill_q + CW'(1);
							flags_q <= flags_q | F_ENQ | F_SRC;
						end
					end
					ACT_DEQ: if (do_deq) begin
						fill_q <= fill_q - CW'(1);
						flags_q <= flags_q | F_DEQ | (head_stale ? F_STL : 6'h00);
					end
					ACT_SETGEN: begin
						if (gen_change) begin
							squeeze_q <= 1'b1;
							dead_gen_q <= live_gen_q;
						end
						live_mod_q <= owner_mod;
						live_gen_q <= generation;
					end
					ACT_NOTESRC: if (source != SRC_NONE) flags_q <= flags_q | F_SRC;
					ACT_NOTECB: begin
						if (forced) flags_q <= flags_q | F_FRC;
						else if (in_guest) begin
							flags_q <= flags_q | F_NAT;
							if (slots_q == '0) slots_q <= PW'(POST_WINDOW);
						end
					end
					ACT_CONSUME: if (slots_q != '0) slots_q <= slots_q - PW'(1);
					default: ;
				endcase
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			acc_q <= do_enq || (do_deq && !head_stale);
			if (do_deq && !head_stale) begin
				osrc_q <= cell_e[0].source; ofrc_q <= cell_e[0].forced;
				oev_q <= cell_e[0].evt_num; omod_q <= cell_e[0].owner_mod;
				ogen_q <= cell_e[0].generation; ohnd_q <= cell_e[0].handler;
			end else begin
				osrc_q <= '0; ofrc_q <= 1'b0; oev_q <= '0; omod_q <= '0;
				ogen_q <= '0; ohnd_q <= '0;
			end
			if (action == ACT_CLASSIFY) begin
				priority if ((flags_q & F_NAT) != '0) verd_q <= VERD_NATURAL;
				else if (!init_zero) verd_q <= VERD_NONE;
				else if (!caller_saw_source && (flags_q & F_SRC) == '0) verd_q <= VERD_NO_SOURCE;
				else if ((flags_q & F_ENQ) == '0) verd_q <= VERD_NOT_ENQ;
				else if ((flags_q & (F_STL | F_FRC)) != '0) verd_q <= VERD_CTX_INV;
				else verd_q <= VERD_NOT_DELIV;
			end else begin
				verd_q <= VERD_NONE;
			end
		end
	end

	assign accepted        = acc_q;
	assign out_source      = osrc_q;
	assign out_forced      = ofrc_q;
	assign out_evt_num     = oev_q;
	assign out_owner_mod   = omod_q;
	assign out_generation  = ogen_q;
	assign out_handler     = ohnd_q;
	assign verdict         = verd_q;
	assign queue_count     = 6'(fill_q);
	assign post_slots_left = 4'(slots_q);

endmodule

// ----- design/gtwq_checker.sv -----
// port-level checks for the work queue, bound to the top level
module gtwq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       accepted,
	input logic [5:0] queue_count,
	input logic [3:0] post_slots_left,
	input logic [2:0] verdict
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(queue_count))
		else $error("result dropped while stalled");

	a_no_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result waits");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> queue_count <= 6'd32 && post_slots_left <= 4'd10)
		else $error("count out of range");

	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> verdict <= 3'd5)
		else $error("bad verdict");

endmodule

bind generation_tagged_work_queue gtwq_checker u_gtwq_checker (.*);

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the generation tagged work queue
`timescale 1ns / 1ps

module tb_top;
	import gtwq_pkg::*;

	localparam int DEPTH      = 32;
	localparam int WINDOW     = 10;
	localparam int IDLE_LIMIT = 2000;
	localparam int N_RANDOM   = 1390;

	localparam logic [2:0] ACT_UNKNOWN = 3'd7;

	typedef struct packed {
		logic [2:0]  action;
		logic [1:0]  source;
		logic [31:0] evt_num;
		logic [31:0] owner_mod;
		logic [31:0] generation;
		logic [31:0] handler;
		logic        forced;
		logic [7:0]  nest_level;
		logic        in_guest;
		logic        init_zero;
		logic        caller_saw_source;
	} work_cmd_t;

	typedef struct packed {
		logic        accepted;
		logic [1:0]  source;
		logic [31:0] evt_num;
		logic [31:0] owner_mod;
		logic [31:0] generation;
		logic [31:0] handler;
		logic        forced;
		logic [5:0]  queue_count;
		logic [2:0]  verdict;
		logic [3:0]  post_slots_left;
	} work_res_t;

	typedef struct packed {
		work_cmd_t cmd;
		logic      typed;
		work_res_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] action = '0;
	logic [1:0] source = '0;
	logic [31:0] evt_num = '0, owner_mod = '0, generation = '0, handler = '0;
	logic forced = 1'b0;
	logic [7:0] nest_level = '0;
	logic in_guest = 1'b0, init_zero = 1'b0, caller_saw_source = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic accepted;
	logic [1:0] out_source;
	logic [31:0] out_evt_num, out_owner_mod, out_generation, out_handler;
	logic out_forced;
	logic [5:0] queue_count;
	logic [2:0] verdict;
	logic [3:0] post_slots_left;

	generation_tagged_work_queue uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	entry_t      shadow_q[$];
	logic [31:0] nxt_event, cur_module, cur_gen;
	logic [5:0]  flags;
	logic [3:0]  slots;

	work_res_t pending_results[$];
	int        fail_count = 0;
	int        idle_cycles = 0;

	function automatic bit gen_is_stale(logic [31:0] g);
		return cur_gen != 0 && g != 0 && g != cur_gen;
	endfunction

	// advance the shadow queue by one command and return its result
	function automatic work_res_t predict_step(work_cmd_t c);
		work_res_t r;
		entry_t e;
		entry_t kept[$];
		r = '0;
		case (c.action)
			ACT_ENQ: begin
				if (c.source != SRC_NONE && shadow_q.size() < DEPTH) begin
					e.source = c.source;
					e.forced = c.forced;
					e.handler = c.handler;
					e.evt_num = c.evt_num;
					if (c.evt_num == 0) begin
						e.evt_num = nxt_event;
						nxt_event = nxt_event + 32'd1;
					end
					e.owner_mod = (c.owner_mod == 0) ? cur_module : c.owner_mod;
					e.generation = (c.generation == 0) ? cur_gen : c.generation;
					if (gen_is_stale(e.generation)) begin
						flags |= F_STL;
					end else begin
						shadow_q.push_back(e);
						flags |= F_ENQ | F_SRC;
						r.accepted = 1'b1;
					end
				end
			end
			ACT_DEQ: begin
				if (c.nest_level == 0 && shadow_q.size() != 0) begin
					e = shadow_q.pop_front();
					flags |= F_DEQ;
					if (gen_is_stale(e.generation)) begin
						flags |= F_STL;
					end else begin
						r.accepted = 1'b1;
						r.source = e.source;
						r.evt_num = e.evt_num;
						r.owner_mod = e.owner_mod;
						r.generation = e.generation;
						r.handler = e.handler;
						r.forced = e.forced;
					end
				end
			end
			ACT_SETGEN: begin
				if (cur_gen != 0 && c.generation != 0 && cur_gen != c.generation) begin
					foreach (shadow_q[i])
						if (shadow_q[i].generation != cur_gen)
							kept.push_back(shadow_q[i]);
					shadow_q = kept;
				end
				cur_module = c.owner_mod;
				cur_gen = c.generation;
			end
			ACT_NOTESRC: begin
				if (c.source != SRC_NONE)
					flags |= F_SRC;
			end
			ACT_NOTECB: begin
				if (c.forced) begin
					flags |= F_FRC;
				end else if (c.in_guest) begin
					flags |= F_NAT;
					if (slots == 0)
						slots = 4'(WINDOW);
				end
			end
			ACT_CONSUME: begin
				if (slots != 0)
					slots = slots - 4'd1;
			end
			ACT_CLASSIFY: begin
				if (flags & F_NAT)
					r.verdict = VERD_NATURAL;
				else if (!c.init_zero)
					r.verdict = VERD_NONE;
				else if (!c.caller_saw_source && !(flags & F_SRC))
					r.verdict = VERD_NO_SOURCE;
				else if (!(flags & F_ENQ))
					r.verdict = VERD_NOT_ENQ;
				else if (flags & (F_STL | F_FRC))
					r.verdict = VERD_CTX_INV;
				else
					r.verdict = VERD_NOT_DELIV;
			end
			default: ;
		endcase
		r.queue_count = 6'(shadow_q.size());
		r.post_slots_left = slots;
		return r;
	endfunction

	function automatic work_cmd_t make_cmd(logic [2:0] a, logic [1:0] s, logic [31:0] ev,
			logic [31:0] m, logic [31:0] g, logic [31:0] h, logic f, logic [7:0] d,
			logic ent, logic iz, logic saw);
		work_cmd_t c;
		c = '{a, s, ev, m, g, h, f, d, ent, iz, saw};
		return c;
	endfunction

	function automatic work_res_t typed_res(logic [5:0] cnt, logic [2:0] v, logic [3:0] sl);
		work_res_t r;
		r = '0;
		r.queue_count = cnt;
		r.verdict = v;
		r.post_slots_left = sl;
		return r;
	endfunction

	// random command, mostly enqueue/dequeue on a few generations
	function automatic work_cmd_t rand_cmd();
		work_cmd_t c;
		int pick;
		c.action = 3'($urandom_range(0, 7));
		pick = $urandom_range(0, 99);
		if (pick < 35) c.action = ACT_ENQ;
		else if (pick < 60) c.action = ACT_DEQ;
		c.source = 2'($urandom_range(0, 3));
		c.evt_num = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom;
		c.owner_mod = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom;
		c.generation = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 3));
		c.handler = $urandom;
		c.forced = ($urandom_range(0, 3) == 0);
		c.nest_level = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'd0;
		c.in_guest = 1'($urandom_range(0, 1));
		c.init_zero = 1'($urandom_range(0, 1));
		c.caller_saw_source = 1'($urandom_range(0, 1));
		return c;
	endfunction

	// idle gap, then hold the transfer until it is taken
	task automatic send_cmd(work_cmd_t c);
		int idle;
		idle = $urandom_range(0, 4);
		if (idle > 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		{action, source, evt_num, owner_mod, generation, handler, forced, nest_level,
			in_guest, init_zero, caller_saw_source} <= c;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// receiver: random stall, then compare each transfer with the oldest expectation
	initial begin
		work_res_t exp_r;
		int stall;
		wait (arst_n);
		forever begin
			stall = $urandom_range(0, 4);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			if (pending_results.size() == 0) begin
				$error("result with no expectation waiting");
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				check_field("accepted", 32'(exp_r.accepted), 32'(accepted));
				check_field("out_source", 32'(exp_r.source), 32'(out_source));
				check_field("out_evt_num", exp_r.evt_num, out_evt_num);
				check_field("out_owner_mod", exp_r.owner_mod, out_owner_mod);
				check_field("out_generation", exp_r.generation, out_generation);
				check_field("out_handler", exp_r.handler, out_handler);
				check_field("out_forced", 32'(exp_r.forced), 32'(out_forced));
				check_field("queue_count", 32'(exp_r.queue_count), 32'(queue_count));
				check_field("verdict", 32'(exp_r.verdict), 32'(verdict));
				check_field("post_slots_left", 32'(exp_r.post_slots_left),
					32'(post_slots_left));
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// stimulus
	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		work_res_t pred;
		work_cmd_t c;
		int n;
		nxt_event = 32'd1;
		cur_module = '0;
		cur_gen = '0;
		flags = '0;
		slots = '0;

		// directed table; typed rows carry a hand-written result
		rows.push_back('{make_cmd(ACT_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0), 1,
			typed_res(0, VERD_NO_SOURCE, 0)});
		rows.push_back('{make_cmd(ACT_DEQ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			typed_res(0, VERD_NONE, 0)});
		rows.push_back('{make_cmd(ACT_ENQ, 0, 5, 5, 5, 5, 0, 0, 0, 0, 0), 1,
			typed_res(0, VERD_NONE, 0)});
		rows.push_back('{make_cmd(ACT_NOTESRC, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{make_cmd(ACT_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0), 1,
			typed_res(0, VERD_NOT_ENQ, 0)});
		rows.push_back('{make_cmd(ACT_SETGEN, 0, 0, 32'hAAAA_0001, 32'd7, 0, 0, 0, 0, 0, 0),
			0, '0});
		rows.push_back('{make_cmd(ACT_ENQ, 1, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, 0, 0, 0), 0, '0});
		rows.push_back('{make_cmd(ACT_ENQ, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd7,
			32'h0, 0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{make_cmd(ACT_ENQ, 2, 0, 0, 32'd9, 0, 0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{make_cmd(ACT_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1), 1,
			typed_res(2, VERD_CTX_INV, 0)});
		rows.push_back('{make_cmd(ACT_DEQ, 0, 0, 0, 0, 0, 0, 8'hFF, 0, 0, 0), 0, '0});
		rows.push_back('{make_cmd(ACT_DEQ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{make_cmd(ACT_ENQ, 1, 0, 0, 32'd8, 0, 0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{make_cmd(ACT_SETGEN, 0, 0, 32'd3, 32'd8, 0, 0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{make_cmd(ACT_NOTECB, 0, 0, 0, 0, 0, 1, 0, 1, 0, 0), 0, '0});
		rows.push_back('{make_cmd(ACT_NOTECB, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{make_cmd(ACT_NOTECB, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0), 0, '0});
		rows.push_back('{make_cmd(ACT_CONSUME, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{make_cmd(ACT_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			typed_res(0, VERD_NATURAL, 9)});
		rows.push_back('{make_cmd(ACT_UNKNOWN, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 8'hFF, 1, 1, 1), 1, typed_res(0, VERD_NONE, 9)});
		rows.push_back('{make_cmd(ACT_SETGEN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			row = rows[i];
			pred = predict_step(row.cmd);
			pending_results.push_back(row.typed ? row.res : pred);
			send_cmd(row.cmd);
		end

		// fill to capacity, then push past it
		for (int k = 0; k < DEPTH + 2; k++) begin
			c = make_cmd(ACT_ENQ, 1, 0, $urandom, 0, $urandom, k[0], 0, 0, 0, 0);
			pending_results.push_back(predict_step(c));
			send_cmd(c);
		end
		// free one slot, refill with the largest event id, then rejects while full
		c = make_cmd(ACT_DEQ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		pending_results.push_back(predict_step(c));
		send_cmd(c);
		for (int k = 0; k < 3; k++) begin
			c = make_cmd(ACT_ENQ, 2, (k == 0) ? 32'hFFFF_FFFF : 32'd0, 0, 0, 0, 0, 0, 0, 0, 0);
			pending_results.push_back(predict_step(c));
			send_cmd(c);
		end

		// random part
		n = 0;
		while (n < N_RANDOM) begin
			c = rand_cmd();
			pending_results.push_back(predict_step(c));
			send_cmd(c);
			n++;
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
